[design/pssi_pkg.sv]
package pssi_pkg;

    // Element geometry: nodes, dofs per node and the stiffness matrix order.
    localparam int NODES        = 3;
    localparam int DOF_PER_NODE = 2;
    localparam int MATDIM       = NODES * DOF_PER_NODE;
    localparam int ROW_W        = 3;

    // Field and internal widths.
    localparam int DN_W   = 16;
    localparam int JV_W   = 32;
    localparam int SUM_W  = 49;
    localparam int G_W    = 32;
    localparam int ENT_W  = 64;
    localparam int E_W    = 31;
    localparam int NU_W   = 15;
    localparam int MU_W   = 31;
    localparam int COEF_W = 48;
    localparam int ACC_W  = 113;
    localparam int CIDX_W = 4;
    localparam int CDAT_W = 32;

    // Register indexes of the configuration port.
    localparam logic [CIDX_W-1:0] REG_YOUNGS  = 4'd0;
    localparam logic [CIDX_W-1:0] REG_POISSON = 4'd1;

    // Reset values of the configuration registers.
    localparam logic [E_W-1:0]  E_RESET  = 31'd65536;
    localparam logic [NU_W-1:0] NU_RESET = 15'd19661;

    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(MATDIM - 1);

    typedef logic signed [G_W-1:0] t_gval;

    typedef struct packed {
        logic signed [DN_W-1:0] dn_dr_0;
        logic signed [DN_W-1:0] dn_ds_0;
        logic signed [DN_W-1:0] dn_dr_1;
        logic signed [DN_W-1:0] dn_ds_1;
        logic signed [DN_W-1:0] dn_dr_2;
        logic signed [DN_W-1:0] dn_ds_2;
        logic signed [JV_W-1:0] jinv_00;
        logic signed [JV_W-1:0] jinv_01;
        logic signed [JV_W-1:0] jinv_10;
        logic signed [JV_W-1:0] jinv_11;
    } t_in_word;

    typedef struct packed {
        logic [ROW_W-1:0]        row_index;
        logic signed [ENT_W-1:0] entry_0;
        logic signed [ENT_W-1:0] entry_1;
        logic signed [ENT_W-1:0] entry_2;
        logic signed [ENT_W-1:0] entry_3;
        logic signed [ENT_W-1:0] entry_4;
        logic signed [ENT_W-1:0] entry_5;
        logic                    last_row;
    } t_out_word;

    // Material coefficients handed from the Lame unit to the lanes.
    typedef struct packed {
        logic [MU_W-1:0]   mu;
        logic [COEF_W-1:0] lam;
        logic [COEF_W-1:0] l2m;
    } t_lame;

endpackage

[design/pssi_lame.sv]
module pssi_lame (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [pssi_pkg::CIDX_W-1:0]   i_cfg_index,
    input  logic [pssi_pkg::CDAT_W-1:0]   i_cfg_data,
    output pssi_pkg::t_lame               o_lame,
    output logic                          o_busy
);

    localparam int NUM_W = 64;
    localparam int DEN_W = 34;
    localparam int CNT_W = 6;
    localparam logic [16:0] ONE_Q16 = 17'd65536;

    typedef enum logic [4:0] {
        ST_PREP = 5'b00001,
        ST_DMU  = 5'b00010,
        ST_DLAM = 5'b00100,
        ST_SUM  = 5'b01000,
        ST_IDLE = 5'b10000
    } t_state;

    t_state                     r_state;
    logic [pssi_pkg::E_W-1:0]   r_e;
    logic [pssi_pkg::NU_W-1:0]  r_nu;
    logic [45:0]                r_nue;
    logic [DEN_W-1:0]           r_dl;
    logic [NUM_W-1:0]           r_num, n_num;
    logic [DEN_W:0]             r_rem, n_rem;
    logic [DEN_W-1:0]           r_den;
    logic [CNT_W-1:0]           r_cnt;
    logic [pssi_pkg::MU_W-1:0]  r_mu;
    logic [pssi_pkg::COEF_W-1:0] r_lam, r_l2m;

    logic [16:0] onep, om2;
    logic [DEN_W:0] trial;
    logic        wr;

    assign onep = ONE_Q16 + 17'(r_nu);
    assign om2  = ONE_Q16 - {1'b0, r_nu, 1'b0};
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign o_busy = (r_state != ST_IDLE);
    assign wr = i_cfg_valid && o_cfg_ready &&
                (i_cfg_index == pssi_pkg::REG_YOUNGS || i_cfg_index == pssi_pkg::REG_POISSON);
    assign o_lame = '{mu: r_mu, lam: r_lam, l2m: r_l2m};

    // One restoring division step: a quotient bit a cycle.
    always_comb begin
        trial = {r_rem[DEN_W-1:0], r_num[NUM_W-1]};
        if (trial >= {1'b0, r_den}) begin
            n_rem = trial - {1'b0, r_den};
            n_num = {r_num[NUM_W-2:0], 1'b1};
        end else begin
            n_rem = trial;
            n_num = {r_num[NUM_W-2:0], 1'b0};
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e  <= pssi_pkg::E_RESET;
            r_nu <= pssi_pkg::NU_RESET;
        end else if (wr) begin
            if (i_cfg_index == pssi_pkg::REG_YOUNGS) begin
                r_e <= i_cfg_data[pssi_pkg::E_W-1:0];
            end else begin
                r_nu <= i_cfg_data[pssi_pkg::NU_W-1:0];
            end
        end
    end

    // Sequencer: mu first, then lambda, then lambda plus twice mu.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_PREP;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                ST_PREP: begin
                    r_nue   <= 46'(r_nu) * 46'(r_e);
                    r_dl    <= DEN_W'(onep) * DEN_W'(om2);
                    r_num   <= NUM_W'({r_e, 16'b0}) + NUM_W'(onep);
                    r_den   <= DEN_W'({onep, 1'b0});
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= ST_DMU;
                end
                ST_DMU: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == '1) begin
                        r_mu    <= n_num[pssi_pkg::MU_W-1:0];
                        r_num   <= NUM_W'({r_nue, 16'b0}) + NUM_W'(r_dl >> 1);
                        r_den   <= r_dl;
                        r_rem   <= '0;
                        r_state <= ST_DLAM;
                    end else begin
                        r_num <= n_num;
                        r_rem <= n_rem;
                    end
                end
                ST_DLAM: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == '1) begin
                        r_lam   <= n_num[pssi_pkg::COEF_W-1:0];
                        r_state <= ST_SUM;
                    end else begin
                        r_num <= n_num;
                        r_rem <= n_rem;
                    end
                end
                ST_SUM: begin
                    r_l2m   <= r_lam + {r_mu, 1'b0};
                    r_state <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (wr) begin
                        r_state <= ST_PREP;
                    end
                end
                default: r_state <= ST_PREP;
            endcase
        end
    end

endmodule

[design/pssi_grad.sv]
module pssi_grad (
    input  logic                i_clk,
    input  logic                i_ld_sum,
    input  logic                i_ld_g,
    input  pssi_pkg::t_in_word  i_word,
    output pssi_pkg::t_gval     o_g [pssi_pkg::MATDIM]
);

    localparam int N = pssi_pkg::NODES;
    localparam int M = pssi_pkg::MATDIM;
    localparam int SW = pssi_pkg::SUM_W;

    logic signed [pssi_pkg::DN_W-1:0] dr [N];
    logic signed [pssi_pkg::DN_W-1:0] ds [N];
    logic signed [SW-1:0] sum [M];
    logic signed [SW-1:0] r_sum [M];
    logic signed [SW-1:0] rnd [M];
    pssi_pkg::t_gval g [M];
    pssi_pkg::t_gval r_g [M];

    assign dr[0] = i_word.dn_dr_0;
    assign ds[0] = i_word.dn_ds_0;
    assign dr[1] = i_word.dn_dr_1;
    assign ds[1] = i_word.dn_ds_1;
    assign dr[2] = i_word.dn_dr_2;
    assign ds[2] = i_word.dn_ds_2;

    // Exact Q21.28 gradients: x column uses dr/dx, ds/dx; y uses dr/dy, ds/dy.
    always_comb begin
        for (int i = 0; i < N; i++) begin
            sum[2*i]   = dr[i] * i_word.jinv_00 + ds[i] * i_word.jinv_10;
            sum[2*i+1] = dr[i] * i_word.jinv_01 + ds[i] * i_word.jinv_11;
        end
    end

    // Round half up to Q16.16 and saturate to 32 bits.
    always_comb begin
        for (int k = 0; k < M; k++) begin
            rnd[k] = r_sum[k] + SW'(2048);
            if ((&rnd[k][SW-1:43]) || !(|rnd[k][SW-1:43])) begin
                g[k] = rnd[k][43:12];
            end else if (rnd[k][SW-1]) begin
                g[k] = {1'b1, {(pssi_pkg::G_W-1){1'b0}}};
            end else begin
                g[k] = {1'b0, {(pssi_pkg::G_W-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld_sum) begin
            r_sum <= sum;
        end
        if (i_ld_g) begin
            r_g <= g;
        end
    end

    assign o_g = r_g;

endmodule

[design/pssi_lane.sv]
module pssi_lane (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  pssi_pkg::t_gval               i_g_row,
    input  pssi_pkg::t_gval               i_g_row_x,
    input  pssi_pkg::t_gval               i_g_col,
    input  pssi_pkg::t_gval               i_g_col_x,
    input  logic                          i_same,
    input  pssi_pkg::t_lame               i_lame,
    output logic signed [pssi_pkg::ENT_W-1:0] o_entry
);

    localparam int AW = pssi_pkg::ACC_W;
    localparam int EW = pssi_pkg::ENT_W;

    // Stage 1: gradient products.
    logic signed [63:0] r_p1, r_p2;
    logic               r_same;
    // Stage 2: partial products of the coefficient multiplications.
    logic signed [48:0] r_hh;
    logic signed [64:0] r_hl;
    logic signed [49:0] r_lh;
    logic signed [65:0] r_ll;
    logic signed [63:0] r_qh;
    logic signed [64:0] r_ql;
    // Stages 3 to 5: partial sums, term sums, rounded total.
    logic signed [66:0] r_m;
    logic signed [AW-1:0] r_cat, r_t2, r_t1, r_t2d, r_acc;

    logic [pssi_pkg::COEF_W-1:0] c1;
    logic signed [31:0] p1h, p2h, mu_s;
    logic signed [32:0] p1l, p2l, c1l;
    logic signed [16:0] c1h;
    logic signed [66:0] hl_x, lh_x;
    logic signed [AW-1:0] m_x, qh_x, ql_x;
    logic ok;

    assign c1   = r_same ? i_lame.l2m : i_lame.lam;
    assign p1h  = r_p1[63:32];
    assign p1l  = {1'b0, r_p1[31:0]};
    assign p2h  = r_p2[63:32];
    assign p2l  = {1'b0, r_p2[31:0]};
    assign c1h  = {1'b0, c1[47:32]};
    assign c1l  = {1'b0, c1[31:0]};
    assign mu_s = {1'b0, i_lame.mu};
    assign hl_x = r_hl;
    assign lh_x = r_lh;
    assign m_x  = r_m;
    assign qh_x = r_qh;
    assign ql_x = r_ql;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1   <= i_g_row * i_g_col;
            r_p2   <= i_g_row_x * i_g_col_x;
            r_same <= i_same;

            r_hh <= p1h * c1h;
            r_hl <= p1h * c1l;
            r_lh <= p1l * c1h;
            r_ll <= p1l * c1l;
            r_qh <= p2h * mu_s;
            r_ql <= p2l * mu_s;

            // The low partial is below 2^64, so the high one stacks on it.
            r_m   <= hl_x + lh_x;
            r_cat <= {r_hh, r_ll[63:0]};
            r_t2  <= (qh_x <<< 32) + ql_x;

            r_t1  <= r_cat + (m_x <<< 32);
            r_t2d <= r_t2;

            r_acc <= r_t1 + r_t2d + AW'(32768);
        end
    end

    // Drop sixteen fraction bits and saturate to the signed 64-bit range.
    assign ok = (&r_acc[AW-1:79]) || !(|r_acc[AW-1:79]);
    assign o_entry = ok ? r_acc[79:16] :
                     (r_acc[AW-1] ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}});

endmodule

[design/plane_strain_stiffness_integrand.sv]
// Channel   Direction  Handshake                 Word
// input     in         i_in_valid / o_in_stall   t_in_word: dN/dr, dN/ds, inverse Jacobian
// result    out        o_out_valid / i_out_stall t_out_word: one row of B^T D B
// config    in         i_cfg_valid / o_cfg_ready index 0 Young's modulus, 1 Poisson ratio
//
// The row sequencer issues one matrix row per cycle to six column lanes while the result
// is not stalled; a new point can be accepted while the rows of the previous one issue.
// A point passes the gradient sum, gradient and hold registers, the lane stages and the
// merge register. After reset and after each register write the Lame unit runs through
// its shared bit-serial divider; input and config stay stalled until it is done.
// A stalled result freezes the lanes; the gradient stages still take the next point.
module plane_strain_stiffness_integrand (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  pssi_pkg::t_in_word           i_in_word,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output pssi_pkg::t_out_word          o_out_word,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [pssi_pkg::CIDX_W-1:0]  i_cfg_index,
    input  logic [pssi_pkg::CDAT_W-1:0]  i_cfg_data
);

    localparam int M = pssi_pkg::MATDIM;
    localparam int RW = pssi_pkg::ROW_W;
    localparam int DEPTH = 5;

    pssi_pkg::t_lame lame;
    logic            busy;
    pssi_pkg::t_gval g1 [M];
    pssi_pkg::t_gval r_g [M];
    logic signed [pssi_pkg::ENT_W-1:0] ent [M];

    logic r_s0v, r_s1v, r_gv, r_ov;
    logic [RW-1:0] r_row;
    logic [DEPTH-1:0] r_vp;
    logic [RW-1:0] r_rp [DEPTH];
    pssi_pkg::t_out_word r_out;

    logic en, fire, ld_g, mv1, accept, fire_last;

    // Stall handling: the lane pipeline moves unless a result waits and is stalled.
    assign en        = !(r_ov && i_out_stall);
    assign fire      = r_gv && en;
    assign fire_last = fire && (r_row == pssi_pkg::LAST_ROW);
    assign ld_g      = r_s1v && (!r_gv || fire_last);
    assign mv1       = r_s0v && (!r_s1v || ld_g);
    assign o_in_stall = busy || (r_s0v && !mv1);
    assign accept    = i_in_valid && !o_in_stall;

    pssi_lame u_lame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_lame      (lame),
        .o_busy      (busy)
    );

    pssi_grad u_grad (
        .i_clk    (i_clk),
        .i_ld_sum (accept),
        .i_ld_g   (mv1),
        .i_word   (i_in_word),
        .o_g      (g1)
    );

    // Gradient hold register for the row sequencer.
    always_ff @(posedge i_clk) begin
        if (ld_g) begin
            r_g <= g1;
        end
    end

    // Occupancy of the gradient stages, hold register and row counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0v <= 1'b0;
            r_s1v <= 1'b0;
            r_gv  <= 1'b0;
            r_row <= '0;
        end else begin
            if (accept) begin
                r_s0v <= 1'b1;
            end else if (mv1) begin
                r_s0v <= 1'b0;
            end
            if (mv1) begin
                r_s1v <= 1'b1;
            end else if (ld_g) begin
                r_s1v <= 1'b0;
            end
            if (ld_g) begin
                r_gv <= 1'b1;
            end else if (fire_last) begin
                r_gv <= 1'b0;
            end
            if (fire) begin
                r_row <= fire_last ? '0 : r_row + 1'b1;
            end
        end
    end

    // Column lanes: lane b pairs row gradient a with column gradient b.
    for (genvar b = 0; b < M; b++) begin : g_lane
        pssi_lane u_lane (
            .i_clk     (i_clk),
            .i_en      (en),
            .i_g_row   (r_g[r_row]),
            .i_g_row_x (r_g[r_row ^ RW'(1)]),
            .i_g_col   (r_g[b]),
            .i_g_col_x (r_g[b ^ 1]),
            .i_same    (r_row[0] == 1'(b % pssi_pkg::DOF_PER_NODE)),
            .i_lame    (lame),
            .o_entry   (ent[b])
        );
    end

    // Valid and row tags travel beside the lane stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp <= '0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_vp <= {r_vp[DEPTH-2:0], r_gv};
            r_ov <= r_vp[DEPTH-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rp[0] <= r_row;
            for (int k = 1; k < DEPTH; k++) begin
                r_rp[k] <= r_rp[k-1];
            end
        end
    end

    // Merge stage: the six lane entries form one result word.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.row_index <= r_rp[DEPTH-1];
            r_out.entry_0   <= ent[0];
            r_out.entry_1   <= ent[1];
            r_out.entry_2   <= ent[2];
            r_out.entry_3   <= ent[3];
            r_out.entry_4   <= ent[4];
            r_out.entry_5   <= ent[5];
            r_out.last_row  <= (r_rp[DEPTH-1] == pssi_pkg::LAST_ROW);
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_word  = r_out;

endmodule
